// ----- sv/srsi_pkg.sv -----
package srsi_pkg;

	// Field widths
	localparam int TS_W       = 48;
	localparam int PRICE_W    = 48;
	localparam int PERIOD_W   = 32;
	localparam int SUM_W      = 64;
	localparam int RSI_W      = 23;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	// Shared adder width: covers the 71-bit product 100*G and the 66-bit division trial.
	localparam int ALU_W = 72;

	// 100 in Q7.16; the quotient of the closing division has RSI_W bits.
	localparam logic [RSI_W-1:0] RSI_SCALE = RSI_W'(6553600);
	localparam int DIV_STEPS = RSI_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OLDEST_TIME     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_PERIOD = CFG_IDX_W'(1);

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OLD,
		ST_FWD,
		ST_GAP,
		ST_KEEP,
		ST_DIFF,
		ST_NEG,
		ST_ACC,
		ST_CHK,
		ST_SUMD,
		ST_M1,
		ST_M2,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ----- sv/srsi_snap_if.sv -----
interface srsi_snap_if import srsi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TS_W-1:0]    snapshot_time;
	logic               price_valid;
	logic [PRICE_W-1:0] price;
	logic               last_item;

	modport source (output valid, snapshot_time, price_valid, price, last_item, input ready);
	modport sink   (input valid, snapshot_time, price_valid, price, last_item, output ready);
endinterface

// ----- sv/srsi_res_if.sv -----
interface srsi_res_if import srsi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RSI_W-1:0] rsi;
	logic             no_data;

	modport source (output valid, rsi, no_data, input ready);
	modport sink   (input valid, rsi, no_data, output ready);
endinterface

// ----- sv/srsi_alu.sv -----
// Shared add/subtract unit. For a subtraction the top bit of sum is set when a >= b.
module srsi_alu import srsi_pkg::*; (
	input  alu_op_t          op,
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output logic [ALU_W:0]   sum
);

	logic [ALU_W:0] b_ext;

	always_comb begin
		case (op)
			ALU_SUB: b_ext = {1'b0, ~b};
			default: b_ext = {1'b0, b};
		endcase
	end

	assign sum = {1'b0, a} + b_ext + ((op == ALU_SUB) ? (ALU_W+1)'(1) : (ALU_W+1)'(0));

endmodule

// ----- sv/sampled_relative_strength_index_top.sv -----
// Sampled relative strength index over a series of price snapshots.
// The snap channel carries snapshots newest first; the item flagged last_item closes
// the series. For every closing item one transaction leaves on the res channel with
// rsi = 100*G/(G+L) in Q7.16 (truncated), or exactly 100 when the loss sum is zero,
// or no_data = 1 and rsi = 0 when no price change was accumulated.
// One snapshot is handled at a time by a sequencer that drives a single shared
// 72-bit adder, one adder operation per cycle. After a snapshot is accepted, ready
// stays low until the sequencer is back in idle, so no new snapshot is taken before
// the last one is through; how long that takes depends on how far the time and price
// checks go. A closing item that needs a division then adds the full sum of G and L,
// two shift-and-add steps forming 100*G, and 23 restoring division steps before its
// result is valid.
// The result is held in an output register until the receiver takes it; while it is
// stalled no new snapshot is accepted, and the series state clears on the hand-off.
// The user must make configuration writes (oldest_time at index 0, sampling_period at
// index 1) only while the block is idle; the block itself does not enforce this.
// Reset clears the sequencer, the series state and both configuration registers.
module sampled_relative_strength_index_top import srsi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	srsi_snap_if.sink             snap,
	srsi_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	// Configuration
	logic [TS_W-1:0]     oldest_time_q;
	logic [PERIOD_W-1:0] sampling_period_q;

	// The accepted snapshot
	logic [TS_W-1:0]    ts_q;
	logic               pv_q;
	logic [PRICE_W-1:0] price_q;
	logic               last_q;

	// Series state
	logic               have_sample_q;
	logic [PRICE_W-1:0] newer_price_q;
	logic [TS_W-1:0]    last_kept_q;
	logic [SUM_W-1:0]   gain_q;
	logic [SUM_W-1:0]   loss_q;
	logic               have_delta_q;
	logic               run_ended_q;

	// Working registers of the sequencer
	logic [TS_W-1:0]      gap_q;
	logic [PRICE_W-1:0]   delta_q;
	logic                 to_gain_q;
	logic [SUM_W:0]       den_q;
	logic [ALU_W-1:0]     acc_q;
	logic [SUM_W:0]       rem_q;
	logic [RSI_W-1:0]     qsh_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Result register
	logic [RSI_W-1:0] rsi_q;
	logic             nd_q;

	// Shared adder
	alu_op_t          alu_op;
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W:0]   alu_sum;
	logic             alu_c;
	logic [SUM_W-1:0] sat_sum;
	state_t           done_st;

	srsi_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	// For a subtraction this is "a >= b"; for an addition it is unused.
	assign alu_c = alu_sum[ALU_W];

	// Saturating 64-bit result of an accumulate: any bit above the sum width means overflow.
	assign sat_sum = (|alu_sum[ALU_W-1:SUM_W]) ? {SUM_W{1'b1}} : alu_sum[SUM_W-1:0];

	// Where a snapshot's processing ends: the closing item goes on to the result.
	assign done_st = last_q ? ST_CHK : ST_IDLE;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (snap.valid) state_d = ST_OLD;
			end
			ST_OLD: begin
				// An ended run ignores everything; a snapshot older than the window ends it.
				if (run_ended_q || !alu_c) state_d = done_st;
				else if (have_sample_q)    state_d = ST_FWD;
				else                       state_d = ST_KEEP;
			end
			ST_FWD: begin
				// A snapshot newer than the last kept one is skipped.
				state_d = alu_c ? ST_GAP : done_st;
			end
			ST_GAP: begin
				// Too close to the last kept snapshot: skipped.
				state_d = alu_c ? ST_KEEP : done_st;
			end
			ST_KEEP: begin
				if (pv_q && have_sample_q) state_d = ST_DIFF;
				else                       state_d = done_st;
			end
			ST_DIFF: state_d = alu_c ? ST_ACC : ST_NEG;
			ST_NEG:  state_d = ST_ACC;
			ST_ACC:  state_d = done_st;
			ST_CHK: begin
				if (!have_delta_q || loss_q == '0) state_d = ST_OUT;
				else                               state_d = ST_SUMD;
			end
			ST_SUMD: state_d = ST_M1;
			ST_M1:   state_d = ST_M2;
			ST_M2:   state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output logic: handshakes and the shared adder's operands.
	always_comb begin
		snap.ready = 1'b0;
		res.valid  = 1'b0;
		alu_op     = ALU_SUB;
		alu_a      = '0;
		alu_b      = '0;
		case (state_q)
			ST_IDLE: snap.ready = 1'b1;
			ST_OLD: begin
				alu_a = ALU_W'(ts_q);
				alu_b = ALU_W'(oldest_time_q);
			end
			ST_FWD: begin
				alu_a = ALU_W'(last_kept_q);
				alu_b = ALU_W'(ts_q);
			end
			ST_GAP: begin
				alu_a = ALU_W'(gap_q);
				alu_b = ALU_W'(sampling_period_q);
			end
			ST_DIFF: begin
				alu_a = ALU_W'(newer_price_q);
				alu_b = ALU_W'(price_q);
			end
			ST_NEG: begin
				alu_a = ALU_W'(price_q);
				alu_b = ALU_W'(newer_price_q);
			end
			ST_ACC: begin
				alu_op = ALU_ADD;
				alu_a  = ALU_W'(to_gain_q ? gain_q : loss_q);
				alu_b  = ALU_W'(delta_q);
			end
			ST_SUMD: begin
				alu_op = ALU_ADD;
				alu_a  = ALU_W'(gain_q);
				alu_b  = ALU_W'(loss_q);
			end
			ST_M1: begin
				// 64*G + 32*G
				alu_op = ALU_ADD;
				alu_a  = ALU_W'({gain_q, 6'b0});
				alu_b  = ALU_W'({gain_q, 5'b0});
			end
			ST_M2: begin
				// ... + 4*G = 100*G
				alu_op = ALU_ADD;
				alu_a  = acc_q;
				alu_b  = ALU_W'({gain_q, 2'b0});
			end
			ST_DIV: begin
				alu_a = ALU_W'({rem_q, qsh_q[RSI_W-1]});
				alu_b = ALU_W'(den_q);
			end
			ST_OUT: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign res.rsi     = rsi_q;
	assign res.no_data = nd_q;

	// Control state, configuration and series state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			oldest_time_q     <= '0;
			sampling_period_q <= '0;
			have_sample_q     <= 1'b0;
			newer_price_q     <= '0;
			last_kept_q       <= '0;
			gain_q            <= '0;
			loss_q            <= '0;
			have_delta_q      <= 1'b0;
			run_ended_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_OLDEST_TIME:     oldest_time_q     <= cfg_data;
					REG_SAMPLING_PERIOD: sampling_period_q <= cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_OLD: begin
					if (!run_ended_q && !alu_c) run_ended_q <= 1'b1;
				end
				ST_KEEP: begin
					// First kept price of the series: nothing to compare against yet.
					if (pv_q && !have_sample_q) begin
						newer_price_q <= price_q;
						last_kept_q   <= ts_q;
						have_sample_q <= 1'b1;
					end
				end
				ST_ACC: begin
					if (to_gain_q) gain_q <= sat_sum;
					else           loss_q <= sat_sum;
					newer_price_q <= price_q;
					last_kept_q   <= ts_q;
					have_delta_q  <= 1'b1;
				end
				ST_OUT: begin
					if (res.ready) begin
						have_sample_q <= 1'b0;
						newer_price_q <= '0;
						last_kept_q   <= '0;
						gain_q        <= '0;
						loss_q        <= '0;
						have_delta_q  <= 1'b0;
						run_ended_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Item, working and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (snap.valid) begin
					ts_q    <= snap.snapshot_time;
					pv_q    <= snap.price_valid;
					price_q <= snap.price;
					last_q  <= snap.last_item;
				end
			end
			ST_FWD: gap_q <= alu_sum[TS_W-1:0];
			ST_DIFF: begin
				// newer >= price counts as a rise; an equal pair adds zero either way.
				delta_q   <= alu_sum[PRICE_W-1:0];
				to_gain_q <= 1'b1;
			end
			ST_NEG: begin
				delta_q   <= alu_sum[PRICE_W-1:0];
				to_gain_q <= 1'b0;
			end
			ST_CHK: begin
				if (!have_delta_q) begin
					rsi_q <= '0;
					nd_q  <= 1'b1;
				end else begin
					rsi_q <= RSI_SCALE;
					nd_q  <= 1'b0;
				end
			end
			ST_SUMD: den_q <= alu_sum[SUM_W:0];
			ST_M1:   acc_q <= alu_sum[ALU_W-1:0];
			ST_M2: begin
				// Numerator is (100*G) << 16. The quotient fits in RSI_W bits, so the
				// bits above the low RSI_W seed the remainder directly.
				rem_q     <= (SUM_W+1)'(alu_sum[ALU_W-2:7]);
				qsh_q     <= {alu_sum[6:0], 16'b0};
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				if (alu_c) rem_q <= alu_sum[SUM_W:0];
				else       rem_q <= {rem_q[SUM_W-1:0], qsh_q[RSI_W-1]};
				qsh_q     <= {qsh_q[RSI_W-2:0], alu_c};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					rsi_q <= {qsh_q[RSI_W-2:0], alu_c};
					nd_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A waiting result blocks new snapshots.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !snap.ready)
		else $error("snapshot accepted while a result is pending");

	// The index never exceeds 100 percent.
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (rsi_q <= RSI_SCALE))
		else $error("rsi above 100 percent");

	// No data reports a zero index.
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && nd_q) |-> (rsi_q == '0))
		else $error("no_data with nonzero rsi");

	// Handing off the result starts a fresh series.
	a_series_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready) |=> (!have_delta_q && !have_sample_q && !run_ended_q
			&& gain_q == '0 && loss_q == '0))
		else $error("series state not cleared after result");
`endif

endmodule

// ----- dv/tb_sampled_relative_strength_index_top.sv -----
module tb_sampled_relative_strength_index_top import srsi_pkg::*; ();

	// The snapshot fields are 48 bits wide. Stimulus arithmetic runs on 64 bits and is
	// clamped to this value.
	localparam logic [63:0] FIELD_MAX = 64'hFFFF_FFFF_FFFF;

	// The run ends if no transaction is seen on either channel for this many cycles.
	// The longest legal silence is the forced receiver hold-off plus one closing
	// division, so this leaves a wide margin.
	localparam int STALL_LIMIT = 2000;

	// One expected result of a closed series.
	typedef struct {
		logic [RSI_W-1:0] rsi;
		logic             no_data;
	} rsi_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	srsi_snap_if snap_if ();
	srsi_res_if res_if ();

	sampled_relative_strength_index_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap     (snap_if),
		.res      (res_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Our own copy of the configuration registers, updated as they are written.
	logic [TS_W-1:0]     cur_oldest_time;
	logic [PERIOD_W-1:0] cur_sampling_period;

	// Series state of the predictor. It mirrors what the block must track while a
	// series streams in: the previously kept price and time, the running up and down
	// totals, whether any price change was seen, and whether the cutoff was crossed.
	bit                 series_primed;
	logic [PRICE_W-1:0] prev_price;
	logic [TS_W-1:0]    prev_time;
	logic [SUM_W-1:0]   up_total;
	logic [SUM_W-1:0]   down_total;
	bit                 delta_seen;
	bit                 cutoff_hit;

	// Results still owed by the block, oldest first.
	rsi_result_t rsi_expected_q[$];

	int error_count;
	int useful_items;
	int quiet_cycles;
	bit idle_en;
	int sink_stall;
	int sink_hold_request;

	// Clock and the single reset at the start of the run.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[47:0];
	endfunction

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
	                                             input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	// Advance the predictor by one accepted snapshot. On the closing snapshot the
	// expected result is queued and the series state starts over. The counted flag
	// tells whether the snapshot was actually looked at, i.e. not ignored because
	// the cutoff had already been crossed.
	task automatic rsi_predict_snapshot(input logic [TS_W-1:0] ts, input logic pv,
	                                    input logic [PRICE_W-1:0] price, input logic is_last,
	                                    output bit counted);
		rsi_result_t outcome;
		logic [127:0] numer;
		logic [127:0] denom;
		logic [127:0] quo;
		counted = 1'b0;
		if (!cutoff_hit) begin
			counted = 1'b1;
			if (ts < cur_oldest_time) begin
				// Anything older than the configured oldest time ends the run.
				cutoff_hit = 1'b1;
			end else if (!series_primed || (ts <= prev_time &&
			             (prev_time - ts) >= TS_W'(cur_sampling_period))) begin
				// Kept unless there is no price; a newer time or one too close to the
				// previous kept snapshot was rejected above.
				if (pv) begin
					if (series_primed) begin
						if (prev_price > price)
							up_total = sat_sum(up_total, SUM_W'(prev_price - price));
						else
							down_total = sat_sum(down_total, SUM_W'(price - prev_price));
						delta_seen = 1'b1;
					end
					prev_price = price;
					prev_time = ts;
					series_primed = 1'b1;
				end
			end
		end
		if (is_last) begin
			outcome.rsi = '0;
			outcome.no_data = 1'b0;
			if (!delta_seen) begin
				outcome.no_data = 1'b1;
			end else if (down_total == '0) begin
				outcome.rsi = RSI_SCALE;
			end else begin
				// Exact wide division, truncated like the block's restoring divider.
				numer = 128'(up_total) * 128'(RSI_SCALE);
				denom = 128'(up_total) + 128'(down_total);
				quo = numer / denom;
				outcome.rsi = quo[RSI_W-1:0];
			end
			rsi_expected_q.push_back(outcome);
			series_primed = 1'b0;
			prev_price = '0;
			prev_time = '0;
			up_total = '0;
			down_total = '0;
			delta_seen = 1'b0;
			cutoff_hit = 1'b0;
		end
	endtask

	// Offer one snapshot, optionally after an idle gap, and hold it until the block
	// takes it. Called and returning on a falling edge; valid stays high on return so
	// back-to-back transactions need no extra cycle.
	task automatic send_snapshot(input logic [TS_W-1:0] ts, input logic pv,
	                             input logic [PRICE_W-1:0] price, input logic is_last);
		int gap;
		bit counted;
		gap = idle_en ? idle_gap() : 0;
		if (gap > 0) begin
			snap_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		snap_if.valid = 1'b1;
		snap_if.snapshot_time = ts;
		snap_if.price_valid = pv;
		snap_if.price = price;
		snap_if.last_item = is_last;
		do
			@(posedge clk);
		while (!snap_if.ready);
		rsi_predict_snapshot(ts, pv, price, is_last, counted);
		if (counted)
			useful_items++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed result has been taken. A snapshot that
	// closes nothing may still be in the sequencer, so the task lets it finish before
	// the caller is free to touch the configuration.
	task automatic wait_drained();
		snap_if.valid = 1'b0;
		while (rsi_expected_q.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
	                              input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_OLDEST_TIME)
			cur_oldest_time = data;
		else
			cur_sampling_period = data[PERIOD_W-1:0];
	endtask

	// One random series, newest snapshot first. Most snapshots step back in time by
	// about the sampling period so they are kept and the price walk produces real
	// gains and losses. Mixed in are snapshots that come too soon, snapshots without
	// a price, times that jump forward, drops below the oldest time, and pure noise.
	task automatic send_random_series(input int len);
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] ts;
		logic [63:0] step;
		logic [63:0] delta;
		logic [63:0] headroom;
		logic pv;
		int r;
		headroom = FIELD_MAX - 64'(cur_oldest_time);
		if ($urandom_range(0, 3) == 0)
			t = 64'(cur_oldest_time) + 64'($urandom_range(0, len * 300));
		else
			t = 64'(cur_oldest_time) + 64'(rand48()) % (headroom + 64'd1);
		if (t > FIELD_MAX)
			t = FIELD_MAX;
		p = 64'(rand48() >> $urandom_range(0, 40));
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			pv = ($urandom_range(0, 9) != 0);
			if (r < 6) begin
				// Time going forward: skipped when newer than the last kept snapshot.
				ts = t + 64'($urandom_range(1, 100));
				if (ts > FIELD_MAX)
					ts = FIELD_MAX;
			end else if (r < 10 && cur_oldest_time != '0) begin
				// Falls below the oldest time and ends the run.
				ts = 64'(rand48()) % 64'(cur_oldest_time);
				t = ts;
			end else if (r < 13) begin
				ts = 64'(rand48());
				p = 64'(rand48());
			end else begin
				if (cur_sampling_period != '0 && $urandom_range(0, 4) == 0)
					step = 64'($urandom_range(0, cur_sampling_period - 1));
				else
					step = 64'(cur_sampling_period) + 64'($urandom_range(0, 200));
				t = (step > t) ? 64'd0 : t - step;
				ts = t;
			end
			r = $urandom_range(0, 9);
			delta = 64'($urandom_range(0, 1 << 20));
			if (r == 0)
				p = 64'(rand48());
			else if (r < 5)
				p = (p + delta > FIELD_MAX) ? FIELD_MAX : p + delta;
			else if (r < 9)
				p = (delta > p) ? 64'd0 : p - delta;
			send_snapshot(ts[TS_W-1:0], pv, p[PRICE_W-1:0], k == len - 1);
		end
	endtask

	function automatic int series_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	// Series that close with nothing to compare: a lone snapshot, and a lone snapshot
	// without a price. Both must report no data with rsi zero.
	task automatic test_no_data();
		send_snapshot(TS_W'(FIELD_MAX), 1'b1, PRICE_W'(12345), 1'b1);
		send_snapshot(TS_W'(100), 1'b0, '0, 1'b1);
	endtask

	// Field extremes with the reset configuration (zero oldest time, zero period).
	task automatic test_edge_values();
		// Full-scale fall from newest to oldest gives the largest possible gain.
		send_snapshot(TS_W'(FIELD_MAX), 1'b1, PRICE_W'(FIELD_MAX), 1'b0);
		send_snapshot(TS_W'(FIELD_MAX - 1), 1'b1, '0, 1'b0);
		// A time newer than the last kept one is skipped.
		send_snapshot(TS_W'(FIELD_MAX), 1'b1, PRICE_W'(5), 1'b0);
		// No price: skipped.
		send_snapshot(TS_W'(FIELD_MAX - 1), 1'b0, PRICE_W'(7), 1'b0);
		// Same time is kept with a zero period; no change adds zero to either side.
		send_snapshot(TS_W'(FIELD_MAX - 1), 1'b1, '0, 1'b0);
		// Full-scale rise to close: equal gain and loss, 50 percent.
		send_snapshot('0, 1'b1, PRICE_W'(FIELD_MAX), 1'b1);
		// Only gains: exactly 100.
		send_snapshot(TS_W'(1000), 1'b1, PRICE_W'(300), 1'b0);
		send_snapshot(TS_W'(900), 1'b1, PRICE_W'(200), 1'b0);
		send_snapshot(TS_W'(800), 1'b1, PRICE_W'(100), 1'b1);
		wait_drained();
	endtask

	// Oldest-time cutoff and sampling period. The period is written with junk above
	// its 32 bits, which the block must drop.
	task automatic test_cutoff();
		write_register(REG_OLDEST_TIME, CFG_DATA_W'(1000));
		write_register(REG_SAMPLING_PERIOD, 48'hABCD_0000_0032);
		send_snapshot(TS_W'(5000), 1'b1, PRICE_W'(1000), 1'b0);
		send_snapshot(TS_W'(4990), 1'b1, PRICE_W'(900), 1'b0);
		send_snapshot(TS_W'(4950), 1'b1, PRICE_W'(800), 1'b0);
		// Below the cutoff: the run ends and the rest of the series is ignored,
		// including the closing snapshot itself.
		send_snapshot(TS_W'(999), 1'b1, PRICE_W'(5), 1'b0);
		send_snapshot(TS_W'(4000), 1'b1, PRICE_W'(9999), 1'b0);
		send_snapshot(TS_W'(3000), 1'b1, PRICE_W'(1), 1'b1);
		// The closing snapshot is the one that crosses the cutoff.
		send_snapshot(TS_W'(2000), 1'b1, PRICE_W'(50), 1'b0);
		send_snapshot(TS_W'(500), 1'b1, PRICE_W'(60), 1'b1);
		// Exactly at the cutoff is kept; one period older falls below it, so no data.
		send_snapshot(TS_W'(1000), 1'b1, PRICE_W'(70), 1'b0);
		send_snapshot(TS_W'(950), 1'b1, PRICE_W'(90), 1'b1);
		wait_drained();
	endtask

	// Random series under one configuration, until enough snapshots were actually
	// looked at. Ignored ones do not count, but a cap keeps the all-cutoff setting
	// from running forever.
	task automatic test_random_phase(input logic [CFG_DATA_W-1:0] oldest_raw,
	                                 input logic [CFG_DATA_W-1:0] period_raw,
	                                 input int budget, input bit idling);
		int sent;
		int len;
		write_register(REG_OLDEST_TIME, oldest_raw);
		write_register(REG_SAMPLING_PERIOD, period_raw);
		idle_en = idling;
		useful_items = 0;
		sent = 0;
		while (useful_items < budget && sent < 3 * budget) begin
			len = series_length();
			send_random_series(len);
			sent += len;
		end
		idle_en = 1'b1;
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering, so
	// the block sits on a finished result and has to stall its input. Afterwards the
	// sender waits until every result is in.
	task automatic test_backpressure();
		write_register(REG_OLDEST_TIME, '0);
		write_register(REG_SAMPLING_PERIOD, CFG_DATA_W'($urandom_range(0, 20)));
		sink_hold_request = 300;
		for (int n = 0; n < 3; n++)
			send_random_series($urandom_range(4, 8));
		wait_drained();
	endtask

	// Receiver: random ready with occasional long stalls, plus a forced hold-off when
	// a test asks for one.
	always @(negedge clk) begin
		if (sink_hold_request > 0) begin
			sink_stall = sink_hold_request;
			sink_hold_request = 0;
		end
		if (sink_stall > 0) begin
			res_if.ready = 1'b0;
			sink_stall--;
		end else begin
			res_if.ready = 1'b1;
			if (idle_en)
				sink_stall = idle_gap();
		end
	end

	// Result checker: every result transaction is matched against the oldest owed
	// result, field by field.
	always @(posedge clk) begin
		rsi_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (rsi_expected_q.size() == 0) begin
				$error("unexpected result: rsi %0d no_data %0d", res_if.rsi, res_if.no_data);
				error_count++;
			end else begin
				want = rsi_expected_q.pop_front();
				if (res_if.rsi !== want.rsi) begin
					$error("rsi: expected %0d, got %0d", want.rsi, res_if.rsi);
					error_count++;
				end
				if (res_if.no_data !== want.no_data) begin
					$error("no_data: expected %0d, got %0d", want.no_data, res_if.no_data);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((snap_if.valid && snap_if.ready) || (res_if.valid && res_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("tb_sampled_relative_strength_index_top failed");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		snap_if.valid = 1'b0;
		snap_if.snapshot_time = '0;
		snap_if.price_valid = 1'b0;
		snap_if.price = '0;
		snap_if.last_item = 1'b0;
		res_if.ready = 1'b0;
		cur_oldest_time = '0;
		cur_sampling_period = '0;
		series_primed = 1'b0;
		prev_price = '0;
		prev_time = '0;
		up_total = '0;
		down_total = '0;
		delta_seen = 1'b0;
		cutoff_hit = 1'b0;
		error_count = 0;
		useful_items = 0;
		quiet_cycles = 0;
		idle_en = 1'b1;
		sink_stall = 0;
		sink_hold_request = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_data();
		test_edge_values();
		test_cutoff();
		// Both registers at zero, then both at their largest values.
		test_random_phase('0, '0, 170, 1'b1);
		test_random_phase(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 40, 1'b1);
		test_random_phase(rand48(), CFG_DATA_W'($urandom_range(1, 500)), 170, 1'b1);
		// A stretch with no idling on either side.
		test_random_phase('0, CFG_DATA_W'($urandom_range(1, 1000)), 170, 1'b0);
		test_random_phase(CFG_DATA_W'($urandom_range(1, 1 << 20)), '0, 170, 1'b1);
		test_random_phase(rand48() >> 8, {16'($urandom()), 32'($urandom_range(0, 100000))},
		                  170, 1'b1);
		test_random_phase(rand48(), {16'($urandom()), 32'($urandom())}, 130, 1'b1);
		test_backpressure();

		// Everything is in; keep the clock running so any stray result still shows.
		repeat (40) @(posedge clk);
		if (error_count == 0 && rsi_expected_q.size() == 0) begin
			$display("tb_sampled_relative_strength_index_top passed");
		end else begin
			$display("tb_sampled_relative_strength_index_top failed");
		end
		$finish;
	end

endmodule
